/* hdl/acrp_pkg.sv */
// ----------------------------------------------------------------------------
// Address range to CIDR prefixes: shared definitions
// Field widths, stream packing positions and the status group that the
// prefix evaluation unit hands to the sequencer.
// ----------------------------------------------------------------------------
package acrp_pkg;

  // Default address width of the walk.
  localparam int unsigned AddrBitsDef = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned FieldW = 32;
  localparam int unsigned LenW   = 6;

  // Input tdata: lower_address, lower_length, upper_address, upper_length.
  localparam int unsigned InLoAddrLsb = 0;
  localparam int unsigned InLoLenLsb  = InLoAddrLsb + FieldW;
  localparam int unsigned InUpAddrLsb = InLoLenLsb + LenW;
  localparam int unsigned InUpLenLsb  = InUpAddrLsb + FieldW;
  localparam int unsigned InPackedW   = InUpLenLsb + LenW;
  localparam int unsigned InTdataW    = ((InPackedW + 7) / 8) * 8;

  // Output tdata: prefix_address, prefix_length.
  localparam int unsigned OutPackedW = FieldW + LenW;
  localparam int unsigned OutTdataW  = ((OutPackedW + 7) / 8) * 8;

  // Status of one evaluation of the candidate block size.
  typedef struct packed {
    logic grow_ok;  // a block twice as large is aligned and still fits
    logic fit_ok;   // the current block lies wholly inside the range
    logic at_end;   // the current block ends exactly on the range end
  } unit_flags_t;

endpackage

/* hdl/acrp_unit.sv */
// ----------------------------------------------------------------------------
// Address range to CIDR prefixes: block evaluation unit
// Shared compare and increment unit. For the cursor and a candidate block
// size it tells whether the block fits, whether the next larger block would
// fit, and gives the address just past the block.
// ----------------------------------------------------------------------------
module acrp_unit #(
  parameter int unsigned ADDR_BITS = acrp_pkg::AddrBitsDef,
  localparam int unsigned KW = $clog2(ADDR_BITS + 1)
) (
  input  logic [ADDR_BITS:0]   cur_i,
  input  logic [ADDR_BITS-1:0] hi_i,
  input  logic [KW-1:0]        k_i,
  output acrp_pkg::unit_flags_t flags_o,
  output logic [ADDR_BITS:0]   cur_next_o
);

  logic [ADDR_BITS:0] mask_k;
  logic [ADDR_BITS:0] mask_k1;
  logic [ADDR_BITS:0] end_k;
  logic [ADDR_BITS:0] end_k1;
  logic [ADDR_BITS:0] hi_ext;
  logic               fit_k1;

  // Host-bit masks for a block of 2^k and of 2^(k+1) addresses.
  always_comb begin
    for (int i = 0; i <= int'(ADDR_BITS); i++) begin
      mask_k[i]  = (i < int'(k_i));
      mask_k1[i] = (i <= int'(k_i));
    end
  end

  // The cursor is aligned to the block, so its last address is an OR.
  assign hi_ext = {1'b0, hi_i};
  assign end_k  = cur_i | mask_k;
  assign end_k1 = cur_i | mask_k1;
  assign fit_k1 = (end_k1 <= hi_ext);

  assign flags_o.fit_ok  = (end_k <= hi_ext);
  assign flags_o.at_end  = (end_k == hi_ext);
  assign flags_o.grow_ok = (int'(k_i) < int'(ADDR_BITS)) && !cur_i[k_i] && fit_k1;

  // First address after the block.
  assign cur_next_o = end_k + {{ADDR_BITS{1'b0}}, 1'b1};

endmodule

/* hdl/acrp_ctrl.sv */
// ----------------------------------------------------------------------------
// Address range to CIDR prefixes: walk sequencer
// Holds the cursor, range end and candidate block size, steps the unit
// once a cycle while the result register can take a value, and loads it.
// ----------------------------------------------------------------------------
module acrp_ctrl #(
  parameter int unsigned ADDR_BITS = acrp_pkg::AddrBitsDef,
  localparam int unsigned KW = $clog2(ADDR_BITS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [ADDR_BITS-1:0]         lo_i,
  input  logic [ADDR_BITS-1:0]         hi_i,
  output logic                         ready_o,
  output logic [ADDR_BITS:0]           cur_o,
  output logic [ADDR_BITS-1:0]         hi_o,
  output logic [KW-1:0]                k_o,
  input  acrp_pkg::unit_flags_t        flags_i,
  input  logic [ADDR_BITS:0]           cur_next_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [acrp_pkg::FieldW-1:0]  out_addr_o,
  output logic [acrp_pkg::LenW-1:0]    out_len_o,
  output logic                         out_last_o,
  output logic                         out_err_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GROW,
    ST_SHRINK
  } state_e;

  state_e                        state_q;
  logic [ADDR_BITS:0]            cur_q;
  logic [ADDR_BITS-1:0]          hi_q;
  logic [KW-1:0]                 k_q;
  logic                          out_valid_q;
  logic [acrp_pkg::FieldW-1:0]   out_addr_q;
  logic [acrp_pkg::LenW-1:0]     out_len_q;
  logic                          out_last_q;
  logic                          out_err_q;
  logic                          step;
  logic [acrp_pkg::LenW-1:0]     cur_len;

  // The sequencer moves on only when the result register can take a value.
  assign step    = !out_valid_q || out_ready_i;
  assign cur_len = acrp_pkg::LenW'(ADDR_BITS) - acrp_pkg::LenW'(k_q);

  // Sequencer state, walk registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_len_q   <= '0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (load_i) begin
            cur_q   <= {1'b0, lo_i};
            hi_q    <= hi_i;
            k_q     <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // With a block of one address the fit test is lower <= upper.
          if (step) begin
            if (flags_i.fit_ok) begin
              state_q <= ST_GROW;
            end else begin
              out_valid_q <= 1'b1;
              out_addr_q  <= '0;
              out_len_q   <= '0;
              out_last_q  <= 1'b1;
              out_err_q   <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_GROW: begin
          // Widen the block while it stays aligned and inside the range.
          if (step) begin
            if (flags_i.grow_ok) begin
              k_q <= k_q + KW'(1);
            end else if (flags_i.fit_ok) begin
              out_valid_q <= 1'b1;
              out_addr_q  <= acrp_pkg::FieldW'(cur_q[ADDR_BITS-1:0]);
              out_len_q   <= cur_len;
              out_last_q  <= flags_i.at_end;
              out_err_q   <= 1'b0;
              cur_q       <= cur_next_i;
              if (flags_i.at_end) begin
                state_q <= ST_IDLE;
              end
            end else begin
              k_q     <= k_q - KW'(1);
              state_q <= ST_SHRINK;
            end
          end
        end
        ST_SHRINK: begin
          // Block sizes only fall from here; alignment always holds.
          if (step) begin
            if (flags_i.fit_ok) begin
              out_valid_q <= 1'b1;
              out_addr_q  <= acrp_pkg::FieldW'(cur_q[ADDR_BITS-1:0]);
              out_len_q   <= cur_len;
              out_last_q  <= flags_i.at_end;
              out_err_q   <= 1'b0;
              cur_q       <= cur_next_i;
              if (flags_i.at_end) begin
                state_q <= ST_IDLE;
              end else begin
                k_q <= k_q - KW'(1);
              end
            end else begin
              k_q <= k_q - KW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign cur_o       = cur_q;
  assign hi_o        = hi_q;
  assign k_o         = k_q;
  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

/* hdl/address_range_to_cidr_prefixes.sv */
// Timing: a range error is registered from the check state after the request
// is taken, and each prefix from the grow or shrink state; a result stays
// in the result register until it is taken.
// Throughput: one range at a time, set by the walk of the shared block
// evaluation unit, which emits at most one prefix per cycle; a step that
// only changes the block size emits no prefix.
// Reset: asynchronous, active low; the block is idle and ready afterwards.
// ----------------------------------------------------------------------------
// Address range to CIDR prefixes: top level
// Turns a lower and an upper prefix into the minimal list of aligned
// prefixes that covers exactly the range between them, in ascending order.
// ----------------------------------------------------------------------------
module address_range_to_cidr_prefixes #(
  parameter int unsigned ADDR_BITS = acrp_pkg::AddrBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // lower_address, lower_length, upper_address, upper_length, zero pad
  input  logic [acrp_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // prefix_address, prefix_length, zero pad
  output logic [acrp_pkg::OutTdataW-1:0] m_axis_tdata,
  // range_error
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);

  localparam int unsigned KW = $clog2(ADDR_BITS + 1);

  logic [ADDR_BITS-1:0]          lo_addr;
  logic [ADDR_BITS-1:0]          up_addr;
  logic [acrp_pkg::LenW-1:0]     lo_len_raw;
  logic [acrp_pkg::LenW-1:0]     up_len_raw;
  logic [acrp_pkg::LenW-1:0]     lo_len;
  logic [acrp_pkg::LenW-1:0]     up_len;
  logic [ADDR_BITS-1:0]          lo_host;
  logic [ADDR_BITS-1:0]          up_host;
  logic [ADDR_BITS-1:0]          range_lo;
  logic [ADDR_BITS-1:0]          range_hi;
  logic                          load;
  logic                          ready;
  logic [ADDR_BITS:0]            cur;
  logic [ADDR_BITS-1:0]          hi;
  logic [KW-1:0]                 k;
  acrp_pkg::unit_flags_t         flags;
  logic [ADDR_BITS:0]            cur_next;
  logic [acrp_pkg::FieldW-1:0]   res_addr;
  logic [acrp_pkg::LenW-1:0]     res_len;

  // Unpack the request; only the low address bits take part.
  assign lo_addr    = s_axis_tdata[acrp_pkg::InLoAddrLsb +: ADDR_BITS];
  assign lo_len_raw = s_axis_tdata[acrp_pkg::InLoLenLsb +: acrp_pkg::LenW];
  assign up_addr    = s_axis_tdata[acrp_pkg::InUpAddrLsb +: ADDR_BITS];
  assign up_len_raw = s_axis_tdata[acrp_pkg::InUpLenLsb +: acrp_pkg::LenW];

  // Mask lengths beyond the address width saturate to a single address.
  assign lo_len = (lo_len_raw > acrp_pkg::LenW'(ADDR_BITS)) ?
                  acrp_pkg::LenW'(ADDR_BITS) : lo_len_raw;
  assign up_len = (up_len_raw > acrp_pkg::LenW'(ADDR_BITS)) ?
                  acrp_pkg::LenW'(ADDR_BITS) : up_len_raw;

  // Host-bit masks and the two ends of the range.
  always_comb begin
    for (int i = 0; i < int'(ADDR_BITS); i++) begin
      lo_host[i] = (i + int'(lo_len) < int'(ADDR_BITS));
      up_host[i] = (i + int'(up_len) < int'(ADDR_BITS));
    end
  end

  assign range_lo = lo_addr & ~lo_host;
  assign range_hi = up_addr | up_host;

  assign load          = s_axis_tvalid && ready;
  assign s_axis_tready = ready;

  acrp_ctrl #(
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .lo_i        (range_lo),
    .hi_i        (range_hi),
    .ready_o     (ready),
    .cur_o       (cur),
    .hi_o        (hi),
    .k_o         (k),
    .flags_i     (flags),
    .cur_next_i  (cur_next),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_addr_o  (res_addr),
    .out_len_o   (res_len),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

  acrp_unit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_unit (
    .cur_i      (cur),
    .hi_i       (hi),
    .k_i        (k),
    .flags_o    (flags),
    .cur_next_o (cur_next)
  );

  // Pack the result, zero padded to whole bytes.
  assign m_axis_tdata = {{(acrp_pkg::OutTdataW - acrp_pkg::OutPackedW){1'b0}},
                         res_len, res_addr};

  // An error result closes its range.
  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result without last marker");

  // An error result carries an empty prefix.
  a_err_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("error result with non-zero prefix");

  // A taken request starts a walk, during which no request is taken.
  a_busy_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a walk is running");

  // Emitted mask lengths never exceed the address width.
  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_len <= acrp_pkg::LenW'(ADDR_BITS)))
    else $error("prefix length beyond address width");

endmodule
